// ===== hdl/pcv_pkg.sv =====
// point cloud voxelizer package: widths, limits, codes and state encoding,
// used by pcv_div, point_cloud_voxelizer, pcv_checker and tb_top; no dependencies
`default_nettype none
package pcv_pkg;
    localparam int COORD_W   = 20;
    localparam int SIZE_W    = 16;
    localparam int VLIM_W    = 15;
    localparam int PLIM_W    = 6;
    localparam int CX_W      = 8;
    localparam int CY_W      = 8;
    localparam int CZ_W      = 4;
    localparam int GRID_X    = 256;
    localparam int GRID_Y    = 256;
    localparam int GRID_Z    = 16;
    localparam int VOXEL_CAP = 16384;
    localparam int MAX_POINTS = 32;
    localparam int VIDX_W    = 14;
    localparam int SLOT_W    = 5;
    localparam int MAP_AW    = CX_W + CY_W + CZ_W;
    localparam int EPOCH_W   = 4;
    localparam int MAP_DW    = EPOCH_W + VIDX_W;
    localparam int INT_W     = 16;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 136;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 4;
    localparam int DIV_CNT_W = 5;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED  = 3'd0,
        ST_OUTSIDE = 3'd1,
        ST_NO_FREE = 3'd2,
        ST_FULL    = 3'd3,
        ST_FRAME   = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X   = 4'd0,
        REG_ORIGIN_Y   = 4'd1,
        REG_ORIGIN_Z   = 4'd2,
        REG_CELL_X     = 4'd3,
        REG_CELL_Y     = 4'd4,
        REG_CELL_Z     = 4'd5,
        REG_VOXEL_LIM  = 4'd6,
        REG_POINTS_LIM = 4'd7
    } reg_idx_t;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_MRD  = 7'b0000100,
        S_MCHK = 7'b0001000,
        S_PRD  = 7'b0010000,
        S_PCHK = 7'b0100000,
        S_CLR  = 7'b1000000
    } state_t;
endpackage
`default_nettype wire

// ===== hdl/pcv_div.sv =====
// restoring divider, one quotient bit per cycle, 20-bit dividend by 16-bit divisor
// uses pcv_pkg
`default_nettype none
module pcv_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [pcv_pkg::COORD_W-1:0]   dividend,
    input  wire logic [pcv_pkg::SIZE_W-1:0]    divisor,
    output logic                               done,
    output logic [pcv_pkg::COORD_W-1:0]        quotient
);
    logic [pcv_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [pcv_pkg::SIZE_W:0]      rem_reg, rem_next;
    logic [pcv_pkg::COORD_W-1:0]   dq_reg, dq_next;
    logic [pcv_pkg::SIZE_W-1:0]    dvs_reg, dvs_next;
    logic [pcv_pkg::SIZE_W:0]      trial;
    logic                          qbit;

    always_comb begin
        trial = {rem_reg[pcv_pkg::SIZE_W-1:0], dq_reg[pcv_pkg::COORD_W-1]};
        qbit  = (trial >= {1'b0, dvs_reg});
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            cnt_next  = '0;
            busy_next = 1'b1;
            rem_next  = '0;
            dq_next   = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = qbit ? (trial - {1'b0, dvs_reg}) : trial;
            dq_next  = {dq_reg[pcv_pkg::COORD_W-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pcv_pkg::DIV_CNT_W'(pcv_pkg::COORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("divider done without work");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg < pcv_pkg::DIV_CNT_W'(pcv_pkg::COORD_W)))
        else $error("divider count overrun");
endmodule
`default_nettype wire

// ===== hdl/point_cloud_voxelizer.sv =====
// point cloud voxelizer top level: cell divide, map lookup and allocation, fill count
// uses pcv_pkg and pcv_div; map and fill-count memories live here
//
// channel  dir  handshake              payload
// s_       in   s_tvalid/s_tready      tuser cmd, tdata px,py,pz,intensity
// m_       out  m_tvalid/m_tready      tuser status, tdata result fields
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// a point passes through accept, the bit-serial cell divide,
// then map read, map check, fill-count read, fill-count check, output load
// an outside point ends after the divide, a point with no free voxel after the map check
// a frame start goes from accept straight to output load; every 15th frame start also sweeps the map
// reset runs a sweep over all 1048576 map entries with s_tready low; cfg is always taken
// a held m_ item stalls the next result load, and s_tready stays low until that load
`default_nettype none
module point_cloud_voxelizer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [pcv_pkg::S_TDATA_W-1:0]   s_tdata,  // px, py, pz, intensity, pad
    input  wire logic                            s_tuser,  // cmd
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [pcv_pkg::M_TDATA_W-1:0]        m_tdata,  // voxel_index, slot, cell_x,
                                                           // cell_y, cell_z, new_voxel,
                                                           // voxels_used, out_x, out_y,
                                                           // out_z, out_intensity, pad
    output logic [pcv_pkg::STATUS_W-1:0]         m_tuser,  // status
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pcv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pcv_pkg::COORD_W-1:0]     cfg_data
);
    localparam int CW = pcv_pkg::COORD_W;

    pcv_pkg::state_t state_reg, state_next;

    logic signed [CW-1:0] ox_reg, oy_reg, oz_reg;
    logic [pcv_pkg::SIZE_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [pcv_pkg::VLIM_W-1:0] vlim_reg;
    logic [pcv_pkg::PLIM_W-1:0] plim_reg;

    logic [pcv_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [pcv_pkg::VLIM_W-1:0]  count_reg, count_next;
    logic [pcv_pkg::MAP_AW-1:0]  clr_reg, clr_next;
    logic                        clr_pend_reg, clr_pend_next;

    logic [CW-1:0] px_reg, py_reg, pz_reg;
    logic [pcv_pkg::INT_W-1:0] int_reg;
    logic bad_reg, bad_next;

    logic [pcv_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [pcv_pkg::VIDX_W-1:0]   vidx_reg, vidx_next;
    logic [pcv_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [pcv_pkg::MAP_AW-1:0]   g_reg, g_next;
    logic                         newv_reg, newv_next;
    logic                         ready_out_reg, ready_out_next;

    logic                         m_valid_reg, m_valid_next;
    logic [pcv_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [pcv_pkg::STATUS_W-1:0]  m_user_reg, m_user_next;

    logic [pcv_pkg::MAP_DW-1:0] map_mem [2**pcv_pkg::MAP_AW];
    logic [pcv_pkg::MAP_DW-1:0] map_q;
    logic                       map_we;
    logic [pcv_pkg::MAP_AW-1:0] map_waddr;
    logic [pcv_pkg::MAP_DW-1:0] map_wdata;

    logic [pcv_pkg::PLIM_W-1:0] pinv_mem [pcv_pkg::VOXEL_CAP];
    logic [pcv_pkg::PLIM_W-1:0] pinv_q;
    logic                       pinv_we;
    logic [pcv_pkg::PLIM_W-1:0] pinv_wdata;

    logic signed [CW:0] dx, dy, dz;
    logic div_start;
    logic [CW-1:0] qx, qy, qz;
    logic dx_done, dy_done, dz_done;
    logic s_fire, out_free;
    logic [pcv_pkg::VLIM_W-1:0] vlim_eff;
    logic [pcv_pkg::PLIM_W-1:0] plim_eff, n_cur;
    logic [pcv_pkg::VLIM_W-1:0] out_count;

    assign s_tready  = (state_reg == pcv_pkg::S_IDLE) && !ready_out_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign dx = $signed({s_tdata[CW-1], s_tdata[CW-1:0]}) - $signed({ox_reg[CW-1], ox_reg});
    assign dy = $signed({s_tdata[2*CW-1], s_tdata[2*CW-1:CW]})
              - $signed({oy_reg[CW-1], oy_reg});
    assign dz = $signed({s_tdata[3*CW-1], s_tdata[3*CW-1:2*CW]})
              - $signed({oz_reg[CW-1], oz_reg});
    assign div_start = s_fire && !s_tuser;

    assign vlim_eff = (vlim_reg < pcv_pkg::VLIM_W'(pcv_pkg::VOXEL_CAP))
                    ? vlim_reg : pcv_pkg::VLIM_W'(pcv_pkg::VOXEL_CAP);
    assign plim_eff = (plim_reg < pcv_pkg::PLIM_W'(pcv_pkg::MAX_POINTS))
                    ? plim_reg : pcv_pkg::PLIM_W'(pcv_pkg::MAX_POINTS);
    assign n_cur    = newv_reg ? '0 : pinv_q;

    pcv_div u_div_x (.aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(dx[CW-1:0]), .divisor(sx_reg), .done(dx_done), .quotient(qx));
    pcv_div u_div_y (.aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(dy[CW-1:0]), .divisor(sy_reg), .done(dy_done), .quotient(qy));
    pcv_div u_div_z (.aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(dz[CW-1:0]), .divisor(sz_reg), .done(dz_done), .quotient(qz));

    always_comb begin
        state_next    = state_reg;
        epoch_next    = epoch_reg;
        count_next    = count_reg;
        clr_next      = clr_reg;
        clr_pend_next = clr_pend_reg;
        bad_next      = bad_reg;
        st_next       = st_reg;
        vidx_next     = vidx_reg;
        slot_next     = slot_reg;
        g_next        = g_reg;
        newv_next     = newv_reg;
        ready_out_next = ready_out_reg;
        map_we        = 1'b0;
        map_waddr     = g_reg;
        map_wdata     = {epoch_reg, vidx_reg};
        pinv_we       = 1'b0;
        pinv_wdata    = n_cur + 1'b1;
        out_count     = count_reg;
        unique case (state_reg)
            pcv_pkg::S_IDLE: begin
                if (s_fire) begin
                    vidx_next = '0;
                    slot_next = '0;
                    newv_next = 1'b0;
                    g_next    = '0;
                    if (s_tuser) begin
                        st_next    = pcv_pkg::ST_FRAME;
                        count_next = '0;
                        if (epoch_reg == {pcv_pkg::EPOCH_W{1'b1}}) begin
                            epoch_next    = pcv_pkg::EPOCH_W'(1);
                            clr_pend_next = 1'b1;
                        end else begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                        ready_out_next = 1'b1;
                    end else begin
                        st_next   = pcv_pkg::ST_STORED;
                        bad_next  = dx[CW] || dy[CW] || dz[CW] || (sx_reg == '0)
                                 || (sy_reg == '0) || (sz_reg == '0);
                        state_next = pcv_pkg::S_DIV;
                    end
                end
            end
            pcv_pkg::S_DIV: begin
                if (dx_done && dy_done && dz_done) begin
                    g_next = {qz[pcv_pkg::CZ_W-1:0], qy[pcv_pkg::CY_W-1:0],
                              qx[pcv_pkg::CX_W-1:0]};
                    if (bad_reg || (qx >= CW'(pcv_pkg::GRID_X))
                        || (qy >= CW'(pcv_pkg::GRID_Y)) || (qz >= CW'(pcv_pkg::GRID_Z))) begin
                        st_next        = pcv_pkg::ST_OUTSIDE;
                        g_next         = '0;
                        ready_out_next = 1'b1;
                        state_next     = pcv_pkg::S_IDLE;
                    end else begin
                        state_next = pcv_pkg::S_MRD;
                    end
                end
            end
            pcv_pkg::S_MRD: begin
                state_next = pcv_pkg::S_MCHK;
            end
            pcv_pkg::S_MCHK: begin
                if (map_q[pcv_pkg::MAP_DW-1:pcv_pkg::VIDX_W] == epoch_reg) begin
                    vidx_next  = map_q[pcv_pkg::VIDX_W-1:0];
                    state_next = pcv_pkg::S_PRD;
                end else if (count_reg >= vlim_eff) begin
                    st_next        = pcv_pkg::ST_NO_FREE;
                    ready_out_next = 1'b1;
                    state_next     = pcv_pkg::S_IDLE;
                end else begin
                    vidx_next  = count_reg[pcv_pkg::VIDX_W-1:0];
                    count_next = count_reg + 1'b1;
                    newv_next  = 1'b1;
                    map_we     = 1'b1;
                    map_wdata  = {epoch_reg, count_reg[pcv_pkg::VIDX_W-1:0]};
                    state_next = pcv_pkg::S_PRD;
                end
            end
            pcv_pkg::S_PRD: begin
                state_next = pcv_pkg::S_PCHK;
            end
            pcv_pkg::S_PCHK: begin
                // every point gets its voxel's fill count written, a new voxel as well
                pinv_we = 1'b1;
                if (n_cur < plim_eff) begin
                    slot_next = n_cur[pcv_pkg::SLOT_W-1:0];
                end else begin
                    st_next    = pcv_pkg::ST_FULL;
                    pinv_wdata = n_cur;
                end
                ready_out_next = 1'b1;
                state_next     = pcv_pkg::S_IDLE;
            end
            pcv_pkg::S_CLR: begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == {pcv_pkg::MAP_AW{1'b1}}) begin
                    state_next = pcv_pkg::S_IDLE;
                end
            end
            default: state_next = pcv_pkg::S_IDLE;
        endcase

        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (ready_out_reg && out_free) begin
            ready_out_next = 1'b0;
            m_valid_next   = 1'b1;
            m_user_next    = st_reg;
            if (st_reg == pcv_pkg::ST_FRAME) begin
                m_data_next = '0;
                if (clr_pend_reg) begin
                    clr_pend_next = 1'b0;
                    clr_next      = '0;
                    state_next    = pcv_pkg::S_CLR;
                end
            end else begin
                m_data_next = {5'd0, int_reg, pz_reg, py_reg, px_reg, out_count, newv_reg,
                               g_reg[pcv_pkg::MAP_AW-1:pcv_pkg::CX_W+pcv_pkg::CY_W],
                               g_reg[pcv_pkg::CX_W+pcv_pkg::CY_W-1:pcv_pkg::CX_W],
                               g_reg[pcv_pkg::CX_W-1:0], slot_reg, vidx_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pcv_pkg::S_CLR;
            epoch_reg     <= pcv_pkg::EPOCH_W'(1);
            count_reg     <= '0;
            clr_reg       <= '0;
            clr_pend_reg  <= 1'b0;
            ready_out_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            ox_reg   <= CW'(0);
            oy_reg   <= -CW'(40000);
            oz_reg   <= -CW'(3000);
            sx_reg   <= pcv_pkg::SIZE_W'(160);
            sy_reg   <= pcv_pkg::SIZE_W'(160);
            sz_reg   <= pcv_pkg::SIZE_W'(400);
            vlim_reg <= pcv_pkg::VLIM_W'(16384);
            plim_reg <= pcv_pkg::PLIM_W'(32);
        end else begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            clr_pend_reg  <= clr_pend_next;
            ready_out_reg <= ready_out_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    pcv_pkg::REG_ORIGIN_X:   ox_reg   <= cfg_data;
                    pcv_pkg::REG_ORIGIN_Y:   oy_reg   <= cfg_data;
                    pcv_pkg::REG_ORIGIN_Z:   oz_reg   <= cfg_data;
                    pcv_pkg::REG_CELL_X:     sx_reg   <= cfg_data[pcv_pkg::SIZE_W-1:0];
                    pcv_pkg::REG_CELL_Y:     sy_reg   <= cfg_data[pcv_pkg::SIZE_W-1:0];
                    pcv_pkg::REG_CELL_Z:     sz_reg   <= cfg_data[pcv_pkg::SIZE_W-1:0];
                    pcv_pkg::REG_VOXEL_LIM:  vlim_reg <= cfg_data[pcv_pkg::VLIM_W-1:0];
                    pcv_pkg::REG_POINTS_LIM: plim_reg <= cfg_data[pcv_pkg::PLIM_W-1:0];
                    default: ;
                endcase
            end
        end
        bad_reg    <= bad_next;
        st_reg     <= st_next;
        vidx_reg   <= vidx_next;
        slot_reg   <= slot_next;
        g_reg      <= g_next;
        newv_reg   <= newv_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        if (s_fire) begin
            px_reg  <= s_tdata[CW-1:0];
            py_reg  <= s_tdata[2*CW-1:CW];
            pz_reg  <= s_tdata[3*CW-1:2*CW];
            int_reg <= s_tdata[3*CW+pcv_pkg::INT_W-1:3*CW];
        end
    end

    // map and fill-count memories
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_q <= map_mem[g_reg];
    end

    always_ff @(posedge aclk) begin
        if (pinv_we) begin
            pinv_mem[vidx_reg] <= pinv_wdata;
        end
        pinv_q <= pinv_mem[vidx_reg];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pcv_pkg::VLIM_W'(pcv_pkg::VOXEL_CAP))
        else $error("voxel count past capacity");
    a_epoch_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        epoch_reg != '0) else $error("epoch reached sweep mark");
    a_alloc_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pcv_pkg::S_MCHK && count_next != count_reg) |=>
        (count_reg == $past(count_reg) + 1'b1)) else $error("bad allocation step");
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pcv_pkg::S_CLR) |-> !s_tready) else $error("item taken during sweep");
endmodule
`default_nettype wire

// ===== dv/pcv_checker.sv =====
// point cloud voxelizer checker: watches the input, result and config channels,
// predicts each result and compares it field by field; depends on pcv_pkg
`timescale 1ns / 100ps
module pcv_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [pcv_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [pcv_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic [pcv_pkg::STATUS_W-1:0]  m_tuser,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [pcv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pcv_pkg::COORD_W-1:0]   cfg_data,
    output int                                 fail_count,
    output int                                 pending
);
    typedef struct packed {
        logic [pcv_pkg::STATUS_W-1:0] status;
        logic [pcv_pkg::VIDX_W-1:0]   voxel_index;
        logic [pcv_pkg::SLOT_W-1:0]   slot;
        logic [pcv_pkg::CX_W-1:0]     cell_x;
        logic [pcv_pkg::CY_W-1:0]     cell_y;
        logic [pcv_pkg::CZ_W-1:0]     cell_z;
        logic                         new_voxel;
        logic [pcv_pkg::VLIM_W-1:0]   voxels_used;
        logic [pcv_pkg::COORD_W-1:0]  out_x;
        logic [pcv_pkg::COORD_W-1:0]  out_y;
        logic [pcv_pkg::COORD_W-1:0]  out_z;
        logic [pcv_pkg::INT_W-1:0]    out_intensity;
    } voxel_res_t;

    int origin_x, origin_y, origin_z;
    int size_x, size_y, size_z;
    int voxel_lim, points_lim;
    bit cell_used [int];
    int cell_voxel [int];
    int fill_count [pcv_pkg::VOXEL_CAP];
    int voxel_total;
    voxel_res_t expected_q [$];

    function automatic bit axis_cell(int p, int org, int size, int grid, output int cell_idx);
        int diff;
        diff = p - org;
        cell_idx = 0;
        if (diff < 0 || size == 0) return 0;
        cell_idx = diff / size;
        return cell_idx < grid;
    endfunction

    function automatic voxel_res_t place_point(logic cmd, logic [pcv_pkg::COORD_W-1:0] x,
            logic [pcv_pkg::COORD_W-1:0] y, logic [pcv_pkg::COORD_W-1:0] z,
            logic [pcv_pkg::INT_W-1:0] inten);
        voxel_res_t r;
        int cx, cy, cz, g, vlim, plim, vidx, n;
        bit ok;
        r = '0;
        if (cmd) begin
            cell_used.delete();
            voxel_total = 0;
            r.status = pcv_pkg::ST_FRAME;
            return r;
        end
        vlim = voxel_lim < pcv_pkg::VOXEL_CAP ? voxel_lim : pcv_pkg::VOXEL_CAP;
        plim = points_lim < pcv_pkg::MAX_POINTS ? points_lim : pcv_pkg::MAX_POINTS;
        r.out_x = x;
        r.out_y = y;
        r.out_z = z;
        r.out_intensity = inten;
        ok = axis_cell(int'($signed(x)), origin_x, size_x, pcv_pkg::GRID_X, cx);
        if (ok) ok = axis_cell(int'($signed(y)), origin_y, size_y, pcv_pkg::GRID_Y, cy);
        if (ok) ok = axis_cell(int'($signed(z)), origin_z, size_z, pcv_pkg::GRID_Z, cz);
        if (!ok) begin
            r.status = pcv_pkg::ST_OUTSIDE;
        end else begin
            r.status = pcv_pkg::ST_STORED;
            r.cell_x = pcv_pkg::CX_W'(cx);
            r.cell_y = pcv_pkg::CY_W'(cy);
            r.cell_z = pcv_pkg::CZ_W'(cz);
            g = (cz * pcv_pkg::GRID_Y + cy) * pcv_pkg::GRID_X + cx;
            ok = 1;
            vidx = 0;
            if (cell_used.exists(g)) begin
                vidx = cell_voxel[g];
            end else if (voxel_total >= vlim) begin
                r.status = pcv_pkg::ST_NO_FREE;
                ok = 0;
            end else begin
                vidx = voxel_total;
                voxel_total++;
                cell_used[g] = 1;
                cell_voxel[g] = vidx;
                fill_count[vidx % pcv_pkg::VOXEL_CAP] = 0;
                r.new_voxel = 1'b1;
            end
            if (ok) begin
                r.voxel_index = pcv_pkg::VIDX_W'(vidx);
                n = fill_count[vidx % pcv_pkg::VOXEL_CAP];
                if (n < plim) begin
                    r.slot = pcv_pkg::SLOT_W'(n);
                    fill_count[vidx % pcv_pkg::VOXEL_CAP] = n + 1;
                end else begin
                    r.status = pcv_pkg::ST_FULL;
                end
            end
        end
        r.voxels_used = pcv_pkg::VLIM_W'(voxel_total);
        return r;
    endfunction

    task automatic cmp_field(string name, longint exp, longint act);
        if (exp != act) begin
            $error("%s mismatch: expected %0h actual %0h", name, exp, act);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        origin_x = 0;
        origin_y = -40000;
        origin_z = -3000;
        size_x = 160;
        size_y = 160;
        size_z = 400;
        voxel_lim = 16384;
        points_lim = 32;
        voxel_total = 0;
    end

    always @(posedge aclk) begin
        voxel_res_t e, a;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pcv_pkg::REG_ORIGIN_X:   origin_x = int'($signed(cfg_data));
                    pcv_pkg::REG_ORIGIN_Y:   origin_y = int'($signed(cfg_data));
                    pcv_pkg::REG_ORIGIN_Z:   origin_z = int'($signed(cfg_data));
                    pcv_pkg::REG_CELL_X:     size_x = int'(cfg_data[pcv_pkg::SIZE_W-1:0]);
                    pcv_pkg::REG_CELL_Y:     size_y = int'(cfg_data[pcv_pkg::SIZE_W-1:0]);
                    pcv_pkg::REG_CELL_Z:     size_z = int'(cfg_data[pcv_pkg::SIZE_W-1:0]);
                    pcv_pkg::REG_VOXEL_LIM:  voxel_lim = int'(cfg_data[pcv_pkg::VLIM_W-1:0]);
                    pcv_pkg::REG_POINTS_LIM: points_lim = int'(cfg_data[pcv_pkg::PLIM_W-1:0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(place_point(s_tuser, s_tdata[19:0], s_tdata[39:20],
                                                 s_tdata[59:40], s_tdata[75:60]));
            if (m_tvalid && m_tready) begin
                a.status        = m_tuser;
                a.voxel_index   = m_tdata[13:0];
                a.slot          = m_tdata[18:14];
                a.cell_x        = m_tdata[26:19];
                a.cell_y        = m_tdata[34:27];
                a.cell_z        = m_tdata[38:35];
                a.new_voxel     = m_tdata[39];
                a.voxels_used   = m_tdata[54:40];
                a.out_x         = m_tdata[74:55];
                a.out_y         = m_tdata[94:75];
                a.out_z         = m_tdata[114:95];
                a.out_intensity = m_tdata[130:115];
                if (expected_q.size() == 0) begin
                    $error("result item with nothing expected");
                    fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    cmp_field("status", e.status, a.status);
                    cmp_field("voxel_index", e.voxel_index, a.voxel_index);
                    cmp_field("slot", e.slot, a.slot);
                    cmp_field("cell_x", e.cell_x, a.cell_x);
                    cmp_field("cell_y", e.cell_y, a.cell_y);
                    cmp_field("cell_z", e.cell_z, a.cell_z);
                    cmp_field("new_voxel", e.new_voxel, a.new_voxel);
                    cmp_field("voxels_used", e.voxels_used, a.voxels_used);
                    cmp_field("out_x", e.out_x, a.out_x);
                    cmp_field("out_y", e.out_y, a.out_y);
                    cmp_field("out_z", e.out_z, a.out_z);
                    cmp_field("out_intensity", e.out_intensity, a.out_intensity);
                end
            end
            pending = expected_q.size();
        end
    end
endmodule

// ===== dv/tb_top.sv =====
// point cloud voxelizer testbench top: clock, reset, point and config stimulus
// and the verdict; depends on pcv_pkg, point_cloud_voxelizer and pcv_checker
`timescale 1ns / 100ps
module tb_top;
    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [pcv_pkg::S_TDATA_W-1:0]   s_tdata;   // px, py, pz, intensity, pad
    logic                            s_tuser;   // cmd
    logic                            m_tvalid;
    logic                            m_tready;
    logic [pcv_pkg::M_TDATA_W-1:0]   m_tdata;   // voxel_index, slot, cell_x, cell_y,
                                                // cell_z, new_voxel, voxels_used, out_x,
                                                // out_y, out_z, out_intensity, pad
    logic [pcv_pkg::STATUS_W-1:0]    m_tuser;   // status
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [pcv_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [pcv_pkg::COORD_W-1:0]     cfg_data;
    int                              fail_count;
    int                              pending;

    bit no_idle;
    bit hold_req;
    int org_x, org_y, org_z, sz_x, sz_y, sz_z;

    point_cloud_voxelizer dut (.*);
    pcv_checker chk (.*);

    initial aclk = 0;
    always #2 aclk = ~aclk;

    initial begin
        #(40_000_000);
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stalls, one long hold on request
    initial begin
        int w;
        m_tready = 0;
        forever begin
            @(negedge aclk);
            w = no_idle ? 0 : $urandom_range(0, 5);
            if (hold_req) begin
                w = 400;
                hold_req = 0;
            end
            if (w > 0) begin
                m_tready <= 0;
                repeat (w) @(negedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_item(int cmd, int x, int y, int z, int inten);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= (cmd != 0);
        s_tdata  <= {4'b0, 16'(inten), 20'(z), 20'(y), 20'(x)};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(pcv_pkg::reg_idx_t idx, int val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= 20'(val);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 0;
        @(negedge aclk);
        case (idx)
            pcv_pkg::REG_ORIGIN_X: org_x = int'($signed(20'(val)));
            pcv_pkg::REG_ORIGIN_Y: org_y = int'($signed(20'(val)));
            pcv_pkg::REG_ORIGIN_Z: org_z = int'($signed(20'(val)));
            pcv_pkg::REG_CELL_X:   sz_x = val & 'hffff;
            pcv_pkg::REG_CELL_Y:   sz_y = val & 'hffff;
            pcv_pkg::REG_CELL_Z:   sz_z = val & 'hffff;
            default: ;
        endcase
    endtask

    task automatic drain;
        s_tvalid <= 0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    function automatic int coord_in_grid(int org, int size, int ncell);
        int c;
        c = $urandom_range(0, ncell - 1);
        return org + c * size + (size > 0 ? int'($urandom_range(0, size - 1)) : 0);
    endfunction

    task automatic set_config(int ox, int oy, int oz, int cx, int cy, int cz,
                              int vl, int pl);
        write_reg(pcv_pkg::REG_ORIGIN_X, ox);
        write_reg(pcv_pkg::REG_ORIGIN_Y, oy);
        write_reg(pcv_pkg::REG_ORIGIN_Z, oz);
        write_reg(pcv_pkg::REG_CELL_X, cx);
        write_reg(pcv_pkg::REG_CELL_Y, cy);
        write_reg(pcv_pkg::REG_CELL_Z, cz);
        write_reg(pcv_pkg::REG_VOXEL_LIM, vl);
        write_reg(pcv_pkg::REG_POINTS_LIM, pl);
    endtask

    initial begin
        int ncx, ncy, ncz;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        cfg_valid = 0;
        cfg_index = pcv_pkg::REG_ORIGIN_X;
        cfg_data = '0;
        no_idle = 0;
        hold_req = 0;
        org_x = 0; org_y = -40000; org_z = -3000;
        sz_x = 160; sz_y = 160; sz_z = 400;
        repeat (10) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // directed: grid corners, edges, extremes, refill of one cell
        send_item(1, -1, 0, -1, 'hffff);
        send_item(0, 0, -40000, -3000, 0);
        send_item(0, 0, -40000, -3000, 'hffff);
        send_item(0, 255*160 + 159, -40000 + 255*160 + 159, -3000 + 15*400 + 399, 'h1234);
        send_item(0, 256*160, 0, 0, 1);
        send_item(0, 0, -40000 + 256*160, 0, 2);
        send_item(0, 0, 0, -3000 + 16*400, 3);
        send_item(0, -1, 0, 0, 4);
        send_item(0, 0, -40001, 0, 5);
        send_item(0, 0, 0, -3001, 6);
        send_item(0, 524287, 524287, 524287, 'h8000);
        send_item(0, -524288, -524288, -524288, 'h7fff);
        send_item(0, 159, -40000 + 159, -3000 + 399, 'haaaa);
        send_item(0, 160, -40000, -3000, 'h5555);
        drain();
        set_config(0, 0, 0, 100, 100, 100, 2, 2);
        write_reg(pcv_pkg::reg_idx_t'(4'd9), 'h12345);
        for (int i = 0; i < 6; i++) send_item(0, (i % 4) * 100, 0, 0, i);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: set_config(0, -40000, -3000, 160, 160, 400, 16384, 32);
                1: set_config(-524288, -524288, -524288, 65535, 65535, 65535, 16384, 32);
                2: set_config(524287, 524287, 524287, 1, 1, 1, 32767, 63);
                3: set_config(0, 0, 0, 100, 100, 100, 5, 3);
                4: set_config(-1000, -1000, -1000, 50, 50, 50, 0, 4);
                5: set_config(1000, 2000, 3000, 10, 20, 30, 20, 0);
                6: set_config(0, 0, 0, 0, 70, 70, 8, 8);
                7: set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
                default: set_config(-20000, -20000, -2000, 3, 5, 7, 16, 1);
            endcase
            no_idle = (ph == 2);
            if (ph == 3) hold_req = 1;
            send_item(1, $urandom, $urandom, $urandom, $urandom);
            for (int i = 0; i < 52; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_item(0, $urandom, $urandom, $urandom, $urandom);
                end else begin
                    if ($urandom_range(0, 3) == 0) begin
                        ncx = pcv_pkg::GRID_X; ncy = pcv_pkg::GRID_Y; ncz = pcv_pkg::GRID_Z;
                    end else begin
                        ncx = $urandom_range(1, 3);
                        ncy = $urandom_range(1, 3);
                        ncz = $urandom_range(1, 2);
                    end
                    send_item(0, coord_in_grid(org_x, sz_x, ncx),
                              coord_in_grid(org_y, sz_y, ncy),
                              coord_in_grid(org_z, sz_z, ncz), $urandom);
                end
            end
            drain();
        end
        no_idle = 0;

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
